// ===== hw/rtl/bsmd_pkg.sv =====
// Shared constants, types and lookup tables for the background subtraction block.
package bsmd_pkg;

   localparam int FRAME_WIDTH   = 640;
   localparam int FRAME_HEIGHT  = 480;
   localparam int UPDATE_PERIOD = 7;

   localparam int PIXELS     = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int ADDR_W     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int PIX_W      = 8;
   localparam int COUNT_W    = 19;
   localparam int PHASE_W    = 4;
   localparam int HALF_PERIOD = UPDATE_PERIOD / 2;
   localparam int TABLE_DEPTH = 1 << PIX_W;

   localparam logic [ADDR_W-1:0]  LAST_ADDR   = ADDR_W'(PIXELS - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
   localparam logic [PHASE_W-1:0] PHASE_MAX   = '1;
   localparam logic [PHASE_W-1:0] PHASE_RESET = PHASE_W'(2);
   localparam logic [PHASE_W-1:0] PHASE_AFTER_UPDATE = PHASE_W'(1);
   localparam logic [PHASE_W-1:0] PHASE_UPDATE = PHASE_W'(UPDATE_PERIOD);
   localparam logic [PIX_W-1:0]   PIX_MAX     = '1;

   localparam logic [PIX_W-1:0]   THRESHOLD_RESET = PIX_W'(150);
   localparam logic [COUNT_W-1:0] LIMIT_RESET     = COUNT_W'(600);

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIFF_THRESHOLD = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_LIMIT    = CSR_INDEX_W'(1);

   localparam int GRAY_ACC_W = 23;
   localparam int GRAY_SHIFT = 14;
   localparam logic [GRAY_ACC_W-1:0] GRAY_COEF_BLUE  = GRAY_ACC_W'(1868);
   localparam logic [GRAY_ACC_W-1:0] GRAY_COEF_GREEN = GRAY_ACC_W'(9617);
   localparam logic [GRAY_ACC_W-1:0] GRAY_COEF_RED   = GRAY_ACC_W'(4899);
   localparam logic [GRAY_ACC_W-1:0] GRAY_ROUND      = GRAY_ACC_W'(8192);

   typedef logic [PIX_W-1:0] div_table_type [TABLE_DEPTH];

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  data;
   } store_write_type;

   // round(i / P), half up
   function automatic div_table_type build_gray_div();
      div_table_type t;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         t[i] = PIX_W'((i + HALF_PERIOD) / UPDATE_PERIOD);
      end
      return t;
   endfunction

   // round(i * (P-1) / P), half up
   function automatic div_table_type build_bg_div();
      div_table_type t;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         t[i] = PIX_W'((i * (UPDATE_PERIOD - 1) + HALF_PERIOD) / UPDATE_PERIOD);
      end
      return t;
   endfunction

   localparam div_table_type GRAY_DIV = build_gray_div();
   localparam div_table_type BG_DIV   = build_bg_div();

   function automatic logic [PIX_W-1:0] to_gray(input logic [PIX_W-1:0] b,
                                                input logic [PIX_W-1:0] g,
                                                input logic [PIX_W-1:0] r);
      logic [GRAY_ACC_W-1:0] acc;
      acc = GRAY_COEF_BLUE * GRAY_ACC_W'(b) + GRAY_COEF_GREEN * GRAY_ACC_W'(g)
          + GRAY_COEF_RED * GRAY_ACC_W'(r) + GRAY_ROUND;
      return acc[GRAY_SHIFT +: PIX_W];
   endfunction

endpackage

// ===== hw/rtl/bsmd_if.sv =====
// Channel interfaces for pixel input, result output and register writes.
interface bsmd_req_if import bsmd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] blue;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] red;
   logic             end_of_frame;

   modport source (output valid, blue, green, red, end_of_frame, input ready);
   modport sink (input valid, blue, green, red, end_of_frame, output ready);
endinterface

interface bsmd_rsp_if import bsmd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             mask_bit;
   logic [PIX_W-1:0] foreground_gray;
   logic             frame_done;
   logic             motion_detected;

   modport source (output valid, mask_bit, foreground_gray, frame_done, motion_detected,
                   input ready);
   modport sink (input valid, mask_bit, foreground_gray, frame_done, motion_detected,
                 output ready);
endinterface

interface bsmd_csr_if import bsmd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/bsmd_bg_store.sv =====
// Background frame store: one read and one write port with write-to-read forwarding.
module bsmd_bg_store import bsmd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  store_write_type   wr,
   output logic [PIX_W-1:0]  rd_data
);

   logic [PIX_W-1:0] mem [PIXELS];
   logic [PIX_W-1:0] rd_data_ff;
   logic [PIX_W-1:0] fwd_data_ff;
   logic             fwd_hit_ff;
   logic             fwd_hit_in;

   assign fwd_hit_in = wr.en && (wr.addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         fwd_data_ff <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_hit_ff <= fwd_hit_in;
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rd_data_ff;

endmodule

// ===== hw/rtl/background_subtract_motion_detect.sv =====
// Top level of the running-average background subtraction and motion detector.
// Takes one BGR pixel per clock in raster order when not stalled and returns one
// result per pixel via the s1 and output registers; the first frame after reset
// only seeds the store and returns nothing. The store is a single-port-read,
// single-port-write memory of FRAME_WIDTH*FRAME_HEIGHT bytes with no clearing pass,
// so the block is ready right after reset. A pixel is read from the store in the
// cycle it is accepted and, on seeding and update frames, written back as it
// leaves s1; a back-to-back access to the same entry is forwarded. req_stream.ready
// follows rsp_stream.ready combinationally, so s1 still fills while a result waits.
module background_subtract_motion_detect import bsmd_pkg::*; (
   input logic clock,
   input logic reset,
   bsmd_req_if.sink   req_stream,
   bsmd_rsp_if.source rsp_stream,
   bsmd_csr_if.sink   csr_write
);

   logic [PIX_W-1:0]   thresh_ff;
   logic [COUNT_W-1:0] limit_ff;

   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               seeded_ff, seeded_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_seeding_ff, s1_update_ff, s1_last_ff;
   logic [ADDR_W-1:0]  s1_addr_ff;
   logic [PIX_W-1:0]   s1_gray_ff;

   logic               out_valid_ff, out_valid_in;
   logic               mask_ff, done_ff, motion_ff;
   logic [PIX_W-1:0]   fg_ff;

   logic               accept, s1_adv, out_load, update_now;
   logic [PIX_W-1:0]   bg_raw, bg_eff, blend, diff;
   logic [PIX_W:0]     blend_sum;
   logic               mask;
   logic [COUNT_W-1:0] count_next;
   logic               motion;
   store_write_type    wr;

   // handshakes
   assign out_load = !out_valid_ff || rsp_stream.ready;
   assign s1_adv   = s1_valid_ff && (s1_seeding_ff || out_load);
   assign req_stream.ready = !s1_valid_ff || s1_adv;
   assign accept   = req_stream.valid && req_stream.ready;
   assign csr_write.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESHOLD_RESET;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_write.valid) begin
         unique case (csr_write.index)
            CSR_DIFF_THRESHOLD: thresh_ff <= csr_write.data[PIX_W-1:0];
            CSR_COUNT_LIMIT:    limit_ff  <= csr_write.data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // input stage: position, frame phase, seeding
   assign update_now = phase_ff >= PHASE_UPDATE;

   always_comb begin
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      seeded_in = seeded_ff;
      if (accept) begin
         if (req_stream.end_of_frame) begin
            pos_in = '0;
            if (!seeded_ff) begin
               seeded_in = 1'b1;
            end else if (update_now) begin
               phase_in = PHASE_AFTER_UPDATE;
            end else if (phase_ff != PHASE_MAX) begin
               phase_in = phase_ff + PHASE_W'(1);
            end
         end else if (pos_ff == LAST_ADDR) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         phase_ff  <= PHASE_RESET;
         seeded_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         seeded_ff <= seeded_in;
      end
   end

   assign s1_valid_in = accept || (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_seeding_ff <= !seeded_ff;
         s1_update_ff  <= update_now;
         s1_last_ff    <= req_stream.end_of_frame;
         s1_addr_ff    <= pos_ff;
         s1_gray_ff    <= to_gray(req_stream.blue, req_stream.green, req_stream.red);
      end
   end

   bsmd_bg_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (pos_ff),
      .wr      (wr),
      .rd_data (bg_raw)
   );

   // blend, compare, count
   assign blend_sum = {1'b0, GRAY_DIV[s1_gray_ff]} + {1'b0, BG_DIV[bg_raw]};
   assign blend     = blend_sum[PIX_W] ? PIX_MAX : blend_sum[PIX_W-1:0];
   assign bg_eff    = s1_update_ff ? blend : bg_raw;
   assign diff      = (bg_eff > s1_gray_ff) ? bg_eff - s1_gray_ff : s1_gray_ff - bg_eff;
   assign mask      = diff > thresh_ff;
   assign count_next = (mask && count_ff != COUNT_MAX) ? count_ff + COUNT_W'(1) : count_ff;
   assign motion    = s1_last_ff && (count_next > limit_ff);

   always_comb begin
      wr.en   = s1_adv && (s1_seeding_ff || s1_update_ff);
      wr.addr = s1_addr_ff;
      wr.data = s1_seeding_ff ? s1_gray_ff : blend;
   end

   always_comb begin
      count_in = count_ff;
      if (s1_adv && !s1_seeding_ff) begin
         count_in = s1_last_ff ? '0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = s1_valid_ff && !s1_seeding_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         mask_ff   <= mask;
         fg_ff     <= mask ? s1_gray_ff : '0;
         done_ff   <= s1_last_ff;
         motion_ff <= motion;
      end
   end

   assign rsp_stream.valid           = out_valid_ff;
   assign rsp_stream.mask_bit        = mask_ff;
   assign rsp_stream.foreground_gray = fg_ff;
   assign rsp_stream.frame_done      = done_ff;
   assign rsp_stream.motion_detected = motion_ff;

   a_no_result_before_seeded: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> seeded_ff)
      else $error("result issued before background was seeded");

   a_phase_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_stream.end_of_frame && seeded_ff && update_now
      |=> phase_ff == PHASE_AFTER_UPDATE)
      else $error("frame phase did not restart after update frame");

   a_position_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_stream.end_of_frame |=> pos_ff == '0)
      else $error("pixel position not cleared at end of frame");

   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_last_ff |=> count_ff == '0)
      else $error("masked count not cleared at end of frame");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for background_subtract_motion_detect: checks every pixel result.
`timescale 1ns / 1ps

module tb_top;
   import bsmd_pkg::*;

   localparam int RESET_CYCLES  = 11;
   localparam int IDLE_PERCENT  = 28;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 2000;
   localparam int PRINT_CAP     = 100;
   localparam int RANDOM_ITEMS  = 460;
   localparam int SEED_PIXELS   = 40;
   localparam int FINAL_FRAME   = 24;
   localparam int LUMA_BLUE     = 1868;
   localparam int LUMA_GREEN    = 9617;
   localparam int LUMA_RED      = 4899;
   localparam int LUMA_ROUND    = 8192;
   localparam int LUMA_SHIFT    = 14;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } bgr_s;

   typedef struct packed {
      logic             mask_bit;
      logic [PIX_W-1:0] foreground_gray;
      logic             frame_done;
      logic             motion_detected;
   } mask_result_s;

   typedef struct packed {
      logic               set_regs;
      logic [PIX_W-1:0]   threshold;
      logic [COUNT_W-1:0] limit;
      bgr_s               color;
      logic               eof;
      logic               typed;
      mask_result_s       want;
   } probe_row_s;

   localparam bgr_s C_BLACK = '{8'd0, 8'd0, 8'd0};
   localparam bgr_s C_WHITE = '{8'd255, 8'd255, 8'd255};
   localparam bgr_s C_BLUE  = '{8'd255, 8'd0, 8'd0};
   localparam bgr_s C_GREEN = '{8'd0, 8'd255, 8'd0};
   localparam bgr_s C_RED   = '{8'd0, 8'd0, 8'd255};
   localparam mask_result_s NO_RESULT = '0;
   localparam int PROBE_ROWS = 13;

   probe_row_s probe_rows [PROBE_ROWS] = '{
      '{1'b0, 8'd0, 19'd0, C_WHITE, 1'b0, 1'b1, '{1'b1, 8'd255, 1'b0, 1'b0}},
      '{1'b0, 8'd0, 19'd0, C_WHITE, 1'b0, 1'b1, '{1'b0, 8'd0, 1'b0, 1'b0}},
      '{1'b0, 8'd0, 19'd0, C_GREEN, 1'b0, 1'b1, '{1'b0, 8'd0, 1'b0, 1'b0}},
      '{1'b0, 8'd0, 19'd0, C_BLACK, 1'b1, 1'b1, '{1'b1, 8'd0, 1'b1, 1'b0}},
      '{1'b0, 8'd0, 19'd0, C_BLACK, 1'b1, 1'b1, '{1'b0, 8'd0, 1'b1, 1'b0}},
      '{1'b1, 8'd0, 19'd0, C_RED, 1'b0, 1'b1, '{1'b1, 8'd76, 1'b0, 1'b0}},
      '{1'b0, 8'd0, 19'd0, C_BLUE, 1'b1, 1'b1, '{1'b1, 8'd29, 1'b1, 1'b1}},
      '{1'b0, 8'd0, 19'd0, C_BLACK, 1'b1, 1'b1, '{1'b0, 8'd0, 1'b1, 1'b0}},
      '{1'b1, 8'd255, 19'd307200, C_WHITE, 1'b1, 1'b1, '{1'b0, 8'd0, 1'b1, 1'b0}},
      '{1'b1, 8'd100, 19'd0, C_WHITE, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 8'd0, 19'd0, C_WHITE, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 8'd0, 19'd0, C_BLACK, 1'b1, 1'b0, NO_RESULT},
      '{1'b0, 8'd0, 19'd0, C_BLACK, 1'b1, 1'b0, NO_RESULT}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   bsmd_req_if pix_if ();
   bsmd_rsp_if res_if ();
   bsmd_csr_if csr_if ();

   background_subtract_motion_detect dut (
      .clock      (clock),
      .reset      (reset),
      .req_stream (pix_if),
      .rsp_stream (res_if),
      .csr_write  (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [PIX_W-1:0]   bg_shadow [PIXELS];
   int unsigned        pixel_pos     = 0;
   logic [PHASE_W-1:0] phase_count   = PHASE_RESET;
   bit                 bg_seeded     = 1'b0;
   logic [COUNT_W-1:0] fg_tally      = '0;
   logic [PIX_W-1:0]   threshold_reg = THRESHOLD_RESET;
   logic [COUNT_W-1:0] limit_reg     = LIMIT_RESET;

   mask_result_s mask_queue [$];
   int  mismatch_count = 0;
   int  results_seen   = 0;
   bit  burst_mode     = 1'b0;
   bit  hold_request   = 1'b0;

   function automatic bgr_s any_color();
      return bgr_s'(24'($urandom));
   endfunction

   task automatic flag_mismatch(input string what);
      if (mismatch_count < PRINT_CAP) begin
         $display("%0t mismatch on result %0d: %s", $realtime, results_seen, what);
      end
      mismatch_count++;
   endtask

   task automatic subtract_background(input bgr_s color, input logic eof,
                                      output bit produced, output mask_result_s res);
      int unsigned gray, bg, diff, at, nxt;
      bit          update_frame, hit;
      logic [COUNT_W-1:0] cnt;
      gray = (LUMA_BLUE * int'(color.blue) + LUMA_GREEN * int'(color.green)
              + LUMA_RED * int'(color.red) + LUMA_ROUND) >> LUMA_SHIFT;
      res = '0;
      produced = 1'b0;
      at = (pixel_pos < PIXELS) ? pixel_pos : 0;
      nxt = (at + 1 >= PIXELS) ? 0 : at + 1;
      if (!bg_seeded) begin
         bg_shadow[at] = PIX_W'(gray);
         bg_seeded = eof;
         pixel_pos = eof ? 0 : nxt;
         fg_tally = '0;
      end else begin
         update_frame = phase_count >= PHASE_UPDATE;
         bg = bg_shadow[at];
         if (update_frame) begin
            bg = (gray + HALF_PERIOD) / UPDATE_PERIOD
               + (bg * (UPDATE_PERIOD - 1) + HALF_PERIOD) / UPDATE_PERIOD;
            if (bg > PIX_MAX) bg = PIX_MAX;
            bg_shadow[at] = PIX_W'(bg);
         end
         diff = (bg > gray) ? bg - gray : gray - bg;
         hit = diff > threshold_reg;
         cnt = fg_tally;
         if (hit && cnt < COUNT_MAX) cnt++;
         res.mask_bit        = hit;
         res.foreground_gray = hit ? PIX_W'(gray) : '0;
         res.frame_done      = eof;
         res.motion_detected = eof && (cnt > limit_reg);
         produced = 1'b1;
         if (eof) begin
            pixel_pos = 0;
            fg_tally = '0;
            if (update_frame) phase_count = PHASE_AFTER_UPDATE;
            else if (phase_count < PHASE_MAX) phase_count++;
         end else begin
            pixel_pos = nxt;
            fg_tally = cnt;
         end
      end
   endtask

   task automatic push_pixel(input bgr_s color, input logic eof, input bit typed,
                             input mask_result_s want);
      bit           produced;
      mask_result_s got;
      while (!burst_mode && $urandom_range(99) < IDLE_PERCENT) begin
         pix_if.valid <= 1'b0;
         @(posedge clock);
      end
      pix_if.valid        <= 1'b1;
      pix_if.blue         <= color.blue;
      pix_if.green        <= color.green;
      pix_if.red          <= color.red;
      pix_if.end_of_frame <= eof;
      @(posedge clock);
      while (!pix_if.ready) @(posedge clock);
      subtract_background(color, eof, produced, got);
      if (produced) mask_queue.push_back(typed ? want : got);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      if (idx == CSR_DIFF_THRESHOLD) threshold_reg = data[PIX_W-1:0];
      else if (idx == CSR_COUNT_LIMIT) limit_reg = data[COUNT_W-1:0];
   endtask

   task automatic drain_results();
      pix_if.valid <= 1'b0;
      while (mask_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : result_sink
      int           hold_left;
      mask_result_s want;
      hold_left = 0;
      res_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && res_if.valid && res_if.ready) begin
            if (mask_queue.size() == 0) begin
               flag_mismatch("result with nothing pending");
            end else begin
               want = mask_queue.pop_front();
               if (res_if.mask_bit !== want.mask_bit)
                  flag_mismatch($sformatf("mask_bit %b, want %b",
                                          res_if.mask_bit, want.mask_bit));
               if (res_if.foreground_gray !== want.foreground_gray)
                  flag_mismatch($sformatf("foreground_gray %0d, want %0d",
                                          res_if.foreground_gray, want.foreground_gray));
               if (res_if.frame_done !== want.frame_done)
                  flag_mismatch($sformatf("frame_done %b, want %b",
                                          res_if.frame_done, want.frame_done));
               if (res_if.motion_detected !== want.motion_detected)
                  flag_mismatch($sformatf("motion_detected %b, want %b",
                                          res_if.motion_detected, want.motion_detected));
            end
            results_seen++;
         end
         if (reset) begin
            res_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            res_if.ready <= 1'b0;
         end else begin
            res_if.ready <= burst_mode || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)
             || (csr_if.valid && csr_if.ready)) quiet = 0;
         else quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int                     len, pick, random_items, frame_no;
      logic [CSR_INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0]  data;
      pix_if.valid        <= 1'b0;
      pix_if.blue         <= '0;
      pix_if.green        <= '0;
      pix_if.red          <= '0;
      pix_if.end_of_frame <= 1'b0;
      csr_if.valid        <= 1'b0;
      csr_if.index        <= '0;
      csr_if.data         <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // seed the background with one frame, alternating black and white up front
      burst_mode = 1'b1;
      for (int i = 0; i < SEED_PIXELS; i++) begin
         push_pixel((i < 4) ? ((i % 2 != 0) ? C_WHITE : C_BLACK) : any_color(),
                    i == SEED_PIXELS - 1, 1'b0, NO_RESULT);
      end
      burst_mode = 1'b0;

      foreach (probe_rows[r]) begin
         if (probe_rows[r].set_regs) begin
            drain_results();
            write_reg(CSR_DIFF_THRESHOLD, CSR_DATA_W'(probe_rows[r].threshold));
            write_reg(CSR_COUNT_LIMIT, CSR_DATA_W'(probe_rows[r].limit));
         end
         push_pixel(probe_rows[r].color, probe_rows[r].eof, probe_rows[r].typed,
                    probe_rows[r].want);
      end

      // hold off the result side to back up the pipeline
      hold_request = 1'b1;
      random_items = 0;
      frame_no = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (frame_no >= 10 && $urandom_range(3) == 0) begin
            drain_results();
            repeat ($urandom_range(1, 3)) begin
               pick = $urandom_range(9);
               if (pick < 4) begin
                  idx = CSR_DIFF_THRESHOLD;
                  case ($urandom_range(2))
                     0: data = '0;
                     1: data = CSR_DATA_W'(PIX_MAX);
                     default: data = $urandom;
                  endcase
               end else if (pick < 8) begin
                  idx = CSR_COUNT_LIMIT;
                  case ($urandom_range(4))
                     0: data = '0;
                     1: data = CSR_DATA_W'(PIXELS);
                     2, 3: data = $urandom_range(0, 20);
                     default: data = $urandom;
                  endcase
               end else begin
                  idx = CSR_INDEX_W'($urandom);
                  data = $urandom;
               end
               write_reg(idx, data);
            end
         end
         burst_mode = (frame_no >= 20 && frame_no < 28);
         len = ($urandom_range(7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
         for (int i = 0; i < len; i++) begin
            push_pixel(any_color(), i == len - 1, 1'b0, NO_RESULT);
            random_items++;
         end
         frame_no++;
      end
      burst_mode = 1'b0;

      // write values wider than the registers, then run one last frame
      drain_results();
      write_reg(CSR_DIFF_THRESHOLD, 32'hFFFF_FF00);
      write_reg(CSR_COUNT_LIMIT, 32'hABC7_FFFE);
      burst_mode = 1'b1;
      for (int i = 0; i < FINAL_FRAME; i++) begin
         push_pixel(any_color(), i == FINAL_FRAME - 1, 1'b0, NO_RESULT);
      end
      burst_mode = 1'b0;

      drain_results();
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/bsmd_pkg.sv
hw/rtl/bsmd_if.sv
hw/rtl/bsmd_bg_store.sv
hw/rtl/background_subtract_motion_detect.sv
sim/tb_top.sv
